FILE: hw/rtl/mwsm_pkg.sv
// Shared widths, register codes, reset values and types of the mecanum wheel speed mixer.
// Used by the front end, back end and top level under hw/rtl; depends on nothing.
package mwsm_pkg;

	localparam int VEL_W       = 16;  // signed Q8.8 velocity
	localparam int GAIN_W      = 16;  // unsigned Q8.8 gain / limit
	localparam int WHEEL_W     = 17;  // signed Q9.8 wheel speed
	localparam int NUM_WHEELS  = 4;
	localparam int PROD_W      = 33;  // linear gain times velocity sum, signed Q.16
	localparam int TURN_W      = 32;  // angular gain times yaw rate, signed Q.16
	localparam int SPD_W       = 34;  // raw wheel speed, signed Q.16
	localparam int MAG_W       = 33;  // raw wheel speed magnitude, Q.16
	localparam int QUOT_W      = 16;  // scaled magnitude, Q8.8
	localparam int NUM_W       = MAG_W + GAIN_W;  // dividend of the scaling divide
	localparam int FRAC_W      = 8;
	localparam int ROUND_HALF  = 1 << (FRAC_W - 1);

	localparam int REG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;
	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 72;

	localparam int QUEUE_DEPTH_DEF = 4;

	localparam logic [GAIN_W-1:0] LINEAR_GAIN_RST  = 16'd51200;
	localparam logic [GAIN_W-1:0] ANGULAR_GAIN_RST = 16'd1510;
	localparam logic [GAIN_W-1:0] SPEED_LIMIT_RST  = 16'd20480;
	localparam logic              REVERSE_RST      = 1'b0;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_LINEAR_GAIN  = 2'd0,
		REG_ANGULAR_GAIN = 2'd1,
		REG_SPEED_LIMIT  = 2'd2,
		REG_REVERSE      = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [GAIN_W-1:0] linear_gain;
		logic [GAIN_W-1:0] angular_gain;
		logic [GAIN_W-1:0] speed_limit;
		logic              reverse;
	} cfg_t;

	// One classified command, handed from the front end to the scaling back end.
	typedef struct packed {
		logic                                 limited;
		logic [MAG_W-1:0]                     peak;
		logic [NUM_WHEELS-1:0]                neg;
		logic [NUM_WHEELS-1:0][MAG_W-1:0]     mag;
	} cmd_t;

endpackage

FILE: hw/rtl/mwsm_front.sv
// Front end: forms the four raw wheel speeds, their signs and magnitudes, the peak
// magnitude and the limit flag. Depends on mwsm_pkg.
module mwsm_front (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  mwsm_pkg::cfg_t                                cfg,
	input  logic                                          in_valid,
	output logic                                          in_ready,
	input  logic signed [mwsm_pkg::VEL_W-1:0]             in_vel_x,
	input  logic signed [mwsm_pkg::VEL_W-1:0]             in_vel_y,
	input  logic signed [mwsm_pkg::VEL_W-1:0]             in_yaw_rate,
	output logic                                          out_valid,
	input  logic                                          out_ready,
	output mwsm_pkg::cmd_t                                out_cmd
);
	import mwsm_pkg::*;

	logic en;

	logic                     vld_s1, vld_s2, vld_s3, vld_s4;
	logic signed [PROD_W-1:0] p_s1, q_s1;
	logic signed [TURN_W-1:0] t_s1;
	logic signed [SPD_W-1:0]  spd_s2 [NUM_WHEELS];
	logic [NUM_WHEELS-1:0]              neg_s3, neg_s4;
	logic [NUM_WHEELS-1:0][MAG_W-1:0]   mag_s3, mag_s4;
	logic [MAG_W-1:0]                   peak_s4;

	logic signed [VEL_W:0]          sum_a, dif_b;
	logic signed [2*VEL_W+1:0]      mul_p, mul_q;
	logic signed [GAIN_W+VEL_W:0]   mul_t;
	logic signed [SPD_W-1:0]        spd_nx [NUM_WHEELS];
	logic [NUM_WHEELS-1:0][MAG_W-1:0] mag_nx;
	logic [MAG_W-1:0]               max01, max23, peak_nx;

	assign en       = !vld_s4 || out_ready;
	assign in_ready = en;

	// stage 1: gain products
	always_comb begin
		sum_a = {in_vel_x[VEL_W-1], in_vel_x} + {in_vel_y[VEL_W-1], in_vel_y};
		dif_b = {in_vel_x[VEL_W-1], in_vel_x} - {in_vel_y[VEL_W-1], in_vel_y};
		mul_p = $signed({1'b0, cfg.linear_gain}) * sum_a;
		mul_q = $signed({1'b0, cfg.linear_gain}) * dif_b;
		mul_t = $signed({1'b0, cfg.angular_gain}) * in_yaw_rate;
	end

	// stage 2: wheel mix, reverse folded into the operand signs
	always_comb begin
		logic signed [SPD_W-1:0] ep, eq, et;
		ep = SPD_W'(p_s1);
		eq = SPD_W'(q_s1);
		et = SPD_W'(t_s1);
		spd_nx[0] = cfg.reverse ? et - ep : ep - et;
		spd_nx[1] = cfg.reverse ? et - eq : eq - et;
		spd_nx[2] = cfg.reverse ? ep + et : -ep - et;
		spd_nx[3] = cfg.reverse ? eq + et : -eq - et;
	end

	// stage 3: magnitudes
	always_comb begin
		for (int k = 0; k < NUM_WHEELS; k++) begin
			mag_nx[k] = spd_s2[k][SPD_W-1] ? MAG_W'(-spd_s2[k]) : MAG_W'(spd_s2[k]);
		end
	end

	// stage 4: peak
	always_comb begin
		max01   = (mag_s3[0] > mag_s3[1]) ? mag_s3[0] : mag_s3[1];
		max23   = (mag_s3[2] > mag_s3[3]) ? mag_s3[2] : mag_s3[3];
		peak_nx = (max01 > max23) ? max01 : max23;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1    <= mul_p[PROD_W-1:0];
			q_s1    <= mul_q[PROD_W-1:0];
			t_s1    <= mul_t[TURN_W-1:0];
			spd_s2  <= spd_nx;
			for (int k = 0; k < NUM_WHEELS; k++) begin
				neg_s3[k] <= spd_s2[k][SPD_W-1];
			end
			mag_s3  <= mag_nx;
			neg_s4  <= neg_s3;
			mag_s4  <= mag_s3;
			peak_s4 <= peak_nx;
		end
	end

	assign out_valid       = vld_s4;
	assign out_cmd.limited = peak_s4 > {{(MAG_W-GAIN_W-FRAC_W){1'b0}}, cfg.speed_limit,
		{FRAC_W{1'b0}}};
	assign out_cmd.peak    = peak_s4;
	assign out_cmd.neg     = neg_s4;
	assign out_cmd.mag     = mag_s4;

endmodule

FILE: hw/rtl/mwsm_queue.sv
// Short FIFO of classified commands between the front end and the back end.
// Depends on mwsm_pkg only through the width its user hands in.
module mwsm_queue #(
	parameter int DEPTH = 4,
	parameter int W     = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [W-1:0] in_data,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [W-1:0] out_data
);
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [W-1:0]     mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             push, pop;

	assign in_ready  = cnt_q != CNT_W'(DEPTH);
	assign out_valid = cnt_q != '0;
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("queue count beyond depth");

	a_cnt_up: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("queue count did not advance on push");

	a_cnt_down: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !push |=> cnt_q == $past(cnt_q) - 1'b1)
		else $error("queue count did not drop on pop");

	a_pass_empty: assert property (@(posedge clk) disable iff (!arst_n)
		push && cnt_q == '0 |=> out_data == $past(in_data))
		else $error("beat written into empty queue not at head");
`endif

endmodule

FILE: hw/rtl/mwsm_back.sv
// Back end: scales limited commands by speed_limit/peak through a pipelined restoring
// divider (one quotient bit per stage, four lanes), rounds the others. Depends on mwsm_pkg.
module mwsm_back (
	input  logic                                                  clk,
	input  logic                                                  arst_n,
	input  logic [mwsm_pkg::GAIN_W-1:0]                           speed_limit,
	input  logic                                                  in_valid,
	output logic                                                  in_ready,
	input  mwsm_pkg::cmd_t                                        in_cmd,
	output logic                                                  out_valid,
	input  logic                                                  out_ready,
	output logic [mwsm_pkg::NUM_WHEELS-1:0][mwsm_pkg::WHEEL_W-1:0] out_wheel,
	output logic                                                  out_limited
);
	import mwsm_pkg::*;

	localparam int DIV_STEPS = QUOT_W;

	typedef struct packed {
		logic                              limited;
		logic [MAG_W-1:0]                  peak;
		logic [NUM_WHEELS-1:0]             neg;
		logic [NUM_WHEELS-1:0][QUOT_W-1:0] rnd;
	} side_t;

	logic en;

	logic                              vld_s1;
	side_t                             side_s1;
	logic [NUM_WHEELS-1:0][NUM_W-1:0]  prod_s1;
	logic [NUM_WHEELS-1:0][NUM_W-1:0]  prod_nx;
	logic [NUM_WHEELS-1:0][QUOT_W-1:0] rnd_nx;

	// divider stages: index 0 holds the loaded dividend, index DIV_STEPS the quotient
	logic                              vld_sd  [DIV_STEPS+1];
	side_t                             side_sd [DIV_STEPS+1];
	logic [NUM_WHEELS-1:0][MAG_W-1:0]  rem_sd  [DIV_STEPS+1];
	logic [NUM_WHEELS-1:0][QUOT_W-1:0] low_sd  [DIV_STEPS+1];
	logic [NUM_WHEELS-1:0][MAG_W-1:0]  rem_ld;
	logic [NUM_WHEELS-1:0][QUOT_W-1:0] low_ld;

	logic [NUM_WHEELS-1:0][WHEEL_W-1:0] wheel_nx;
	logic [NUM_WHEELS-1:0][WHEEL_W-1:0] wheel_q;
	logic                               limited_q;
	logic                               out_valid_q;

	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	// stage 1: limit products and plain rounding
	always_comb begin
		logic [MAG_W:0] rsum;
		rsum = '0;
		for (int k = 0; k < NUM_WHEELS; k++) begin
			prod_nx[k] = in_cmd.mag[k] * speed_limit;
			rsum       = {1'b0, in_cmd.mag[k]} + (MAG_W+1)'(ROUND_HALF);
			rnd_nx[k]  = rsum[FRAC_W +: QUOT_W];
		end
	end

	// stage 2: add half the peak for round to nearest, split into remainder and low bits
	always_comb begin
		logic [NUM_W-1:0] num;
		num = '0;
		for (int k = 0; k < NUM_WHEELS; k++) begin
			num       = prod_s1[k] + NUM_W'(side_s1.peak >> 1);
			rem_ld[k] = num[NUM_W-1:QUOT_W];
			low_ld[k] = num[QUOT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_sd[0] <= 1'b0;
		end else if (en) begin
			vld_s1    <= in_valid;
			vld_sd[0] <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1         <= prod_nx;
			side_s1.limited <= in_cmd.limited;
			side_s1.peak    <= in_cmd.peak;
			side_s1.neg     <= in_cmd.neg;
			side_s1.rnd     <= rnd_nx;
			side_sd[0]      <= side_s1;
			rem_sd[0]       <= rem_ld;
			low_sd[0]       <= low_ld;
		end
	end

	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
		logic [NUM_WHEELS-1:0][MAG_W-1:0]  rem_nx;
		logic [NUM_WHEELS-1:0][QUOT_W-1:0] low_nx;

		// shift in the next dividend bit, subtract the peak where it fits
		always_comb begin
			logic [MAG_W:0] trial;
			trial = '0;
			for (int k = 0; k < NUM_WHEELS; k++) begin
				trial = {rem_sd[j][k], low_sd[j][k][QUOT_W-1]};
				if (trial >= {1'b0, side_sd[j].peak}) begin
					rem_nx[k] = MAG_W'(trial - {1'b0, side_sd[j].peak});
					low_nx[k] = {low_sd[j][k][QUOT_W-2:0], 1'b1};
				end else begin
					rem_nx[k] = trial[MAG_W-1:0];
					low_nx[k] = {low_sd[j][k][QUOT_W-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sd[j+1] <= 1'b0;
			end else if (en) begin
				vld_sd[j+1] <= vld_sd[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_sd[j+1]  <= rem_nx;
				low_sd[j+1]  <= low_nx;
				side_sd[j+1] <= side_sd[j];
			end
		end
	end

	// output: pick scaled or rounded magnitude, restore the sign
	always_comb begin
		logic [WHEEL_W-1:0] ext;
		ext = '0;
		for (int k = 0; k < NUM_WHEELS; k++) begin
			ext = side_sd[DIV_STEPS].limited ? {1'b0, low_sd[DIV_STEPS][k]}
				: {1'b0, side_sd[DIV_STEPS].rnd[k]};
			wheel_nx[k] = side_sd[DIV_STEPS].neg[k] ? (~ext + 1'b1) : ext;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= vld_sd[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wheel_q   <= wheel_nx;
			limited_q <= side_sd[DIV_STEPS].limited;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_wheel   = wheel_q;
	assign out_limited = limited_q;

endmodule

FILE: hw/rtl/mecanum_wheel_speed_mixer.sv
// Top level of the mecanum wheel speed mixer: configuration registers, stream ports,
// front end, command queue and scaling back end. Depends on mwsm_pkg and all mwsm_* modules.
//
// Usage:
//   s_axis carries one velocity command per beat (vel_x, vel_y, yaw_rate, signed Q8.8).
//   m_axis returns one beat per command: four signed Q9.8 wheel speeds in tdata and the
//   limited flag in tuser, in command order.
//   cfg_we/cfg_index/cfg_wdata write linear_gain (0), angular_gain (1), speed_limit (2)
//   and reverse (3, bit 0); write only while no command is in flight.
// Timing:
//   An accepted input beat passes through 4 front-end stages, 1 queue slot, 2 product
//   stages, 16 divider stages (one quotient bit each) and the output register.
//   Throughput is one command per cycle while m_axis is not stalled; the divider and all
//   multipliers are pipelined.
// Reset and stall:
//   arst_n clears all valid state and loads the register defaults (gain 200.0,
//   turn gain 1510/256, limit 80.0, no reverse).
//   When m_axis stalls the back end holds, the queue (QUEUE_DEPTH beats) keeps filling
//   from the front end, and s_axis_tready drops only once the queue is full and the
//   front end's last stage is occupied.
module mecanum_wheel_speed_mixer #(
	parameter int QUEUE_DEPTH = mwsm_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [mwsm_pkg::REG_IDX_W-1:0]        cfg_index,
	input  logic [mwsm_pkg::CFG_DATA_W-1:0]       cfg_wdata,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  logic [mwsm_pkg::IN_TDATA_W-1:0]       s_axis_tdata,  // vel_x, vel_y, yaw_rate
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// wheel_slot0, wheel_slot1, wheel_slot2, wheel_slot3, zero fill
	output logic [mwsm_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
	output logic [0:0]                            m_axis_tuser   // limited
);
	import mwsm_pkg::*;

	cfg_t cfg_q;

	logic  fq_valid, fq_ready;
	cmd_t  fq_cmd;
	logic  qb_valid, qb_ready;
	cmd_t  qb_cmd;
	logic [NUM_WHEELS-1:0][WHEEL_W-1:0] wheel;
	logic  limited;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.linear_gain  <= LINEAR_GAIN_RST;
			cfg_q.angular_gain <= ANGULAR_GAIN_RST;
			cfg_q.speed_limit  <= SPEED_LIMIT_RST;
			cfg_q.reverse      <= REVERSE_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_LINEAR_GAIN:  cfg_q.linear_gain  <= cfg_wdata;
				REG_ANGULAR_GAIN: cfg_q.angular_gain <= cfg_wdata;
				REG_SPEED_LIMIT:  cfg_q.speed_limit  <= cfg_wdata;
				REG_REVERSE:      cfg_q.reverse      <= cfg_wdata[0];
			endcase
		end
	end

	mwsm_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_vel_x    (s_axis_tdata[VEL_W-1:0]),
		.in_vel_y    (s_axis_tdata[2*VEL_W-1:VEL_W]),
		.in_yaw_rate (s_axis_tdata[3*VEL_W-1:2*VEL_W]),
		.out_valid   (fq_valid),
		.out_ready   (fq_ready),
		.out_cmd     (fq_cmd)
	);

	mwsm_queue #(
		.DEPTH (QUEUE_DEPTH),
		.W     ($bits(cmd_t))
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fq_valid),
		.in_ready  (fq_ready),
		.in_data   (fq_cmd),
		.out_valid (qb_valid),
		.out_ready (qb_ready),
		.out_data  (qb_cmd)
	);

	mwsm_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.speed_limit (cfg_q.speed_limit),
		.in_valid    (qb_valid),
		.in_ready    (qb_ready),
		.in_cmd      (qb_cmd),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_wheel   (wheel),
		.out_limited (limited)
	);

	assign m_axis_tdata = {{(OUT_TDATA_W - NUM_WHEELS*WHEEL_W){1'b0}},
		wheel[3], wheel[2], wheel[1], wheel[0]};
	assign m_axis_tuser = limited;

endmodule
